@@ sv/fwpd_pkg.sv @@
`default_nettype none

package fwpd_pkg;

   // Fixed field widths of the input and result words.
   localparam int MANT_W  = 64;
   localparam int EXP_W   = 15;
   localparam int DIGIT_W = 4;

   // Entries held between the classifier and the converter.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified word waiting for conversion.
   typedef struct packed {
      logic                overflow;
      logic [MANT_W-1:0]   mantissa;
      logic [EXP_W-1:0]    exponent;
   } fwpd_entry_type;

endpackage

`default_nettype wire

@@ sv/fwpd_front.sv @@
`default_nettype none

module fwpd_front
   import fwpd_pkg::*;
#(
   parameter int WHOLE_BITS = 128
) (
   input  wire logic                 start,
   input  wire logic                 queue_full,
   input  wire logic [MANT_W-1:0]    req_mantissa,
   input  wire logic [EXP_W-1:0]     req_exponent,
   output logic                      push,
   output fwpd_entry_type            push_entry
);

   logic accept;
   logic negative;

   // A word is taken whenever the queue has room; a negative exponent has no
   // whole part and is dropped here without reaching the converter.
   assign accept   = start && !queue_full;
   assign negative = req_exponent[EXP_W-1];
   assign push     = accept && !negative;

   assign push_entry.overflow = req_exponent >= EXP_W'(WHOLE_BITS);
   assign push_entry.mantissa = req_mantissa;
   assign push_entry.exponent = req_exponent;

endmodule

`default_nettype wire

@@ sv/fwpd_queue.sv @@
`default_nettype none

module fwpd_queue
   import fwpd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  fwpd_entry_type       push_entry,
   input  wire logic            pop,
   output logic                 full,
   output logic                 not_empty,
   output fwpd_entry_type       head
);

   fwpd_entry_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ sv/fwpd_back.sv @@
`default_nettype none

module fwpd_back
   import fwpd_pkg::*;
#(
   parameter int WHOLE_BITS = 128,
   parameter int DIGITS     = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  fwpd_entry_type            head,
   output logic                      pop,
   output logic                      rsp_strobe,
   output logic [DIGIT_W-1:0]        rsp_digit,
   output logic                      rsp_last_digit,
   output logic                      rsp_overflow
);

   localparam int STEP_W = $clog2(WHOLE_BITS);
   localparam int EMIT_W = $clog2(DIGITS);
   localparam int BCD_W  = DIGITS * DIGIT_W;

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      EMIT
   } state_type;

   state_type             state_ff,   state_in;
   logic [MANT_W-1:0]     mant_ff,    mant_in;
   logic [STEP_W-1:0]     exp_ff,     exp_in;
   logic [STEP_W-1:0]     step_ff,    step_in;
   logic [BCD_W-1:0]      bcd_ff,     bcd_in;
   logic [EMIT_W-1:0]     emit_ff,    emit_in;
   logic                  strobe_ff,  strobe_in;
   logic [DIGIT_W-1:0]    digit_ff,   digit_in;
   logic                  last_ff,    last_in;
   logic                  ovf_ff,     ovf_in;

   logic                  take_bit;
   logic                  bit_in;
   logic [BCD_W-1:0]      adjusted;

   assign pop = (state_ff == IDLE) && head_valid;

   // Step b of the conversion feeds whole-part bit b; bits above the exponent
   // are zero, and from the exponent down the mantissa is fed from its top.
   assign take_bit = step_ff <= exp_ff;
   assign bit_in   = take_bit && mant_ff[MANT_W-1];

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] > DIGIT_W'(4)) begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      mant_in   = mant_ff;
      exp_in    = exp_ff;
      step_in   = step_ff;
      bcd_in    = bcd_ff;
      emit_in   = emit_ff;
      strobe_in = 1'b0;
      digit_in  = digit_ff;
      last_in   = last_ff;
      ovf_in    = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (head_valid) begin
               if (head.overflow) begin
                  strobe_in = 1'b1;
                  digit_in  = '0;
                  last_in   = 1'b1;
                  ovf_in    = 1'b1;
               end else begin
                  mant_in  = head.mantissa;
                  exp_in   = head.exponent[STEP_W-1:0];
                  step_in  = STEP_W'(WHOLE_BITS - 1);
                  bcd_in   = '0;
                  state_in = CONVERT;
               end
            end
         end
         CONVERT: begin
            bcd_in = {adjusted[BCD_W-2:0], bit_in};
            if (take_bit) begin
               mant_in = {mant_ff[MANT_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               emit_in  = '0;
               state_in = EMIT;
            end
         end
         EMIT: begin
            strobe_in = 1'b1;
            digit_in  = bcd_ff[BCD_W-1 -: DIGIT_W];
            last_in   = emit_ff == EMIT_W'(DIGITS - 1);
            bcd_in    = {bcd_ff[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
            emit_in   = emit_ff + 1'b1;
            if (emit_ff == EMIT_W'(DIGITS - 1)) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         ovf_ff    <= ovf_in;
      end
      mant_ff  <= mant_in;
      exp_ff   <= exp_in;
      step_ff  <= step_in;
      bcd_ff   <= bcd_in;
      emit_ff  <= emit_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit      = digit_ff;
   assign rsp_last_digit = last_ff;
   assign rsp_overflow   = ovf_ff;

endmodule

`default_nettype wire

@@ sv/float_whole_part_to_decimal.sv @@
`default_nettype none

// Converts the whole part of a float to decimal. A word is the 64-bit
// mantissa (top bit is the integer bit) and the signed exponent of that top
// bit; the block drops fraction bits and answers with DIGITS decimal digits,
// most significant first, leading zeros included, the last one flagged by
// rsp_last_digit. A negative exponent gives no response at all. An exponent
// of WHOLE_BITS or more gives a single response with rsp_overflow and
// rsp_last_digit set and a zero digit. Responses appear for one cycle under
// rsp_strobe and cannot be held off, so the receiver must take each one as
// it comes; the digits of one word arrive on consecutive cycles.
// A word is taken on a rising edge with start high and busy low. A front end
// classifies it and places it in a two-entry queue, so busy only rises when
// two words are already waiting behind the converter. The converter runs
// double dabble with one shift-and-adjust step per whole-part bit, then
// shifts out one digit per cycle. A normal word occupies it through IDLE,
// CONVERT and EMIT, an overflow word in IDLE only, and a negative word not
// at all. That converter loop sets the sustained rate.

module float_whole_part_to_decimal
   import fwpd_pkg::*;
#(
   parameter int WHOLE_BITS = 128,
   parameter int DIGITS     = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [MANT_W-1:0]          req_mantissa,
   input  wire logic signed [EXP_W-1:0]    req_exponent,
   output logic                            rsp_strobe,
   output logic [DIGIT_W-1:0]              rsp_digit,
   output logic                            rsp_last_digit,
   output logic                            rsp_overflow
);

   logic             push;
   fwpd_entry_type   push_entry;
   logic             queue_full;
   logic             head_valid;
   fwpd_entry_type   head;
   logic             pop;

   // Busy only reflects queue space, never the converter's state.
   assign busy = queue_full;

   fwpd_front #(
      .WHOLE_BITS (WHOLE_BITS)
   ) u_front (
      .start        (start),
      .queue_full   (queue_full),
      .req_mantissa (req_mantissa),
      .req_exponent ($unsigned(req_exponent)),
      .push         (push),
      .push_entry   (push_entry)
   );

   fwpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (head_valid),
      .head       (head)
   );

   // The converter keeps its result word in registers, so the response
   // ports come straight from flip-flops.
   fwpd_back #(
      .WHOLE_BITS (WHOLE_BITS),
      .DIGITS     (DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

`default_nettype wire

@@ sv/fwpd_checker.sv @@
`default_nettype none

module fwpd_checker
   import fwpd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic signed [EXP_W-1:0]    req_exponent,
   input  wire logic                       rsp_strobe,
   input  wire logic [DIGIT_W-1:0]         rsp_digit,
   input  wire logic                       rsp_last_digit,
   input  wire logic                       rsp_overflow
);

   // An overflow response stands alone with a zero digit.
   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overflow |-> rsp_last_digit && rsp_digit == '0)
      else $error("overflow response is not a lone zero digit");

   // Every digit is decimal.
   a_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit <= DIGIT_W'(9))
      else $error("response digit above nine");

   // The digits of one word come on consecutive cycles.
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_digit |=> rsp_strobe && !rsp_overflow)
      else $error("digit run broken before its last digit");

   // Nothing is answered right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("response strobe right after reset");

   // Busy cannot rise without a word having been taken.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      !busy && !(start && req_exponent >= 0) |=> !busy)
      else $error("busy rose without an accepted word");

endmodule

bind float_whole_part_to_decimal fwpd_checker u_checker (.*);

`default_nettype wire
